// ===== rtl/tfe_pkg.sv =====
package tfe_pkg;

  localparam int unsigned DataFileBytesDef = 1024;
  localparam int unsigned SearchSpanDef    = 20;

  localparam int unsigned CcBytes  = 15;
  localparam int unsigned UriBytes = 23;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [55:0] AppId      = 56'hD2_7600_0085_0101;
  localparam logic [47:0] SelPattern = 48'hA4_000C_0200_01;

  localparam logic [1:0] FuncSelect = 2'd0;
  localparam logic [1:0] FuncRead   = 2'd1;
  localparam logic [1:0] FuncUpdate = 2'd2;

  localparam logic [CfgIdxW-1:0] RegCapId  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegDataId = CfgIdxW'(1);

  localparam logic [15:0] CapIdReset  = 16'hE103;
  localparam logic [15:0] DataIdReset = 16'h0001;

  localparam logic [1:0] PhaseIdle = 2'd0;
  localparam logic [1:0] PhaseApp  = 2'd1;
  localparam logic [1:0] PhaseCc   = 2'd2;
  localparam logic [1:0] PhaseData = 2'd3;

  localparam logic [1:0] FileNone = 2'd0;
  localparam logic [1:0] FileCc   = 2'd1;
  localparam logic [1:0] FileData = 2'd2;

  typedef struct packed {
    logic        launch;
    logic [15:0] off;
    logic [7:0]  n;
    logic        cap;
  } rd_cmd_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] chunk;
    logic [3:0]  nbytes;
    logic        last;
  } rd_res_t;

  function automatic logic [7:0] uri_byte(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:    v = 8'h00;
      5'd1:    v = 8'h15;
      5'd2:    v = 8'hD1;
      5'd3:    v = 8'h01;
      5'd4:    v = 8'h11;
      5'd5:    v = 8'h55;
      5'd6:    v = 8'h01;
      5'd7:    v = 8'h73;
      5'd8:    v = 8'h74;
      5'd9:    v = 8'h2E;
      5'd10:   v = 8'h63;
      5'd11:   v = 8'h6F;
      5'd12:   v = 8'h6D;
      5'd13:   v = 8'h2F;
      5'd14:   v = 8'h73;
      5'd15:   v = 8'h74;
      5'd16:   v = 8'h32;
      5'd17:   v = 8'h35;
      5'd18:   v = 8'h2D;
      5'd19:   v = 8'h64;
      5'd20:   v = 8'h65;
      5'd21:   v = 8'h6D;
      5'd22:   v = 8'h6F;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] cc_byte(input logic [3:0] idx, input logic [15:0] dfid,
                                         input logic [15:0] fsize);
    logic [7:0] v;
    case (idx)
      4'd1:         v = 8'h0F;
      4'd2:         v = 8'h20;
      4'd4, 4'd6:   v = 8'h7F;
      4'd7:         v = 8'h04;
      4'd8:         v = 8'h06;
      4'd9:         v = dfid[15:8];
      4'd10:        v = dfid[7:0];
      4'd11:        v = fsize[15:8];
      4'd12:        v = fsize[7:0];
      default:      v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tfe_store.sv =====
module tfe_store #(
  parameter int unsigned DATA_FILE_BYTES = tfe_pkg::DataFileBytesDef,
  localparam int unsigned AW = $clog2(DATA_FILE_BYTES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o,
  output logic          ready_o
);
  import tfe_pkg::*;

  localparam logic [AW-1:0] LastAddr = AW'(DATA_FILE_BYTES - 1);
  localparam logic [AW-1:0] UriEnd   = AW'(UriBytes);

  logic [7:0]    mem [DATA_FILE_BYTES];
  logic [AW-1:0] clr_q, clr_d;
  logic          done_q, done_d;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    rdata_q;

  always_comb begin
    clr_d  = clr_q;
    done_d = done_q;
    if (!done_q) begin
      clr_d = clr_q + AW'(1);
      if (clr_q == LastAddr) begin
        done_d = 1'b1;
      end
    end
    if (done_q) begin
      mem_we    = we_i;
      mem_waddr = waddr_i;
      mem_wdata = wdata_i;
    end else begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = (clr_q < UriEnd) ? uri_byte(clr_q[4:0]) : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      clr_q  <= clr_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = done_q;

endmodule

// ===== rtl/tfe_reader.sv =====
module tfe_reader #(
  parameter int unsigned DATA_FILE_BYTES = tfe_pkg::DataFileBytesDef,
  localparam int unsigned AW = $clog2(DATA_FILE_BYTES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tfe_pkg::rd_cmd_t cmd_i,
  input  logic [15:0]      data_file_id_i,
  output logic             re_o,
  output logic [AW-1:0]    raddr_o,
  input  logic [7:0]       rdata_i,
  output tfe_pkg::rd_res_t res_o,
  output logic             busy_o
);
  import tfe_pkg::*;

  localparam logic [15:0] FileSize = 16'(DATA_FILE_BYTES);

  logic        active_q, active_d;
  logic [15:0] off_q, off_d;
  logic [7:0]  n_q, n_d;
  logic        cap_q, cap_d;
  logic [7:0]  iss_q, iss_d;
  logic        pend_q, pend_d;
  logic [7:0]  pidx_q, pidx_d;
  logic [7:0]  cc_q, cc_d;
  logic [63:0] chunk_q, chunk_d;
  logic [16:0] addr;
  logic [2:0]  lane;
  logic [7:0]  cap_byte;
  logic        last_byte;

  always_comb begin
    active_d = active_q;
    off_d    = off_q;
    n_d      = n_q;
    cap_d    = cap_q;
    iss_d    = iss_q;
    pend_d   = 1'b0;
    pidx_d   = pidx_q;
    chunk_d  = chunk_q;
    addr     = {1'b0, off_q} + 17'(iss_q);
    cc_d     = cc_byte(addr[3:0], data_file_id_i, FileSize);
    re_o     = 1'b0;
    raddr_o  = addr[AW-1:0];
    res_o    = '0;

    if (active_q && iss_q != n_q) begin
      re_o   = !cap_q;
      pend_d = 1'b1;
      pidx_d = iss_q;
      iss_d  = iss_q + 8'd1;
    end

    lane      = pidx_q[2:0];
    cap_byte  = cap_q ? cc_q : rdata_i;
    last_byte = (pidx_q == n_q - 8'd1);
    if (pend_q) begin
      chunk_d = ((lane == 3'd0) ? 64'd0 : chunk_q) | (64'(cap_byte) << {lane, 3'b000});
      if (lane == 3'd7 || last_byte) begin
        res_o.valid  = 1'b1;
        res_o.chunk  = chunk_d;
        res_o.nbytes = {1'b0, lane} + 4'd1;
        res_o.last   = last_byte;
      end
      if (last_byte) begin
        active_d = 1'b0;
      end
    end

    if (cmd_i.launch) begin
      active_d = 1'b1;
      off_d    = cmd_i.off;
      n_d      = cmd_i.n;
      cap_d    = cmd_i.cap;
      iss_d    = 8'd0;
      pend_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
      iss_q    <= '0;
    end else begin
      active_q <= active_d;
      pend_q   <= pend_d;
      iss_q    <= iss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q   <= off_d;
    n_q     <= n_d;
    cap_q   <= cap_d;
    pidx_q  <= pidx_d;
    cc_q    <= cc_d;
    chunk_q <= chunk_d;
  end

  assign busy_o = active_q;

endmodule

// ===== rtl/type4_tag_file_engine.sv =====
// Channel   Direction  Handshake                  Payload
// command   in         start_i high, busy_o low   func, file_offset, byte_length,
//                                                 data_byte, data_last
// result    out        result_valid_o, one cycle  read_chunk, chunk_bytes, status,
//                                                 result_last
// config    in         cfg_valid_i & cfg_ready_o  cfg_index_i, cfg_data_i
//
// Select and update items are taken while busy_o is low; a last item's result is
// registered and appears in the cycle after it. A read occupies the block, one byte
// per cycle, data-file bytes via the single read port of the data store, with a
// result every eight bytes and after the last. After reset the data store is filled
// with its default contents, busy_o high; configuration writes are taken meanwhile.
// Results cannot be stalled: each stands on the ports for exactly one cycle.
module type4_tag_file_engine #(
  parameter int unsigned DATA_FILE_BYTES = tfe_pkg::DataFileBytesDef,
  parameter int unsigned SEARCH_SPAN     = tfe_pkg::SearchSpanDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   func_i,
  input  logic [15:0]                  file_offset_i,
  input  logic [7:0]                   byte_length_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         data_last_i,
  output logic                         result_valid_o,
  output logic [63:0]                  read_chunk_o,
  output logic [3:0]                   chunk_bytes_o,
  output logic                         status_o,
  output logic                         result_last_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tfe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [15:0]                  cfg_data_i
);
  import tfe_pkg::*;

  localparam int unsigned AW = $clog2(DATA_FILE_BYTES);
  localparam logic [15:0] Span    = 16'(SEARCH_SPAN);
  localparam logic [16:0] FileEnd = 17'(DATA_FILE_BYTES);

  logic [15:0] cap_id_q, cap_id_d;
  logic [15:0] data_id_q, data_id_d;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  file_q, file_d;
  logic [55:0] win_q, win_d;
  logic [15:0] pos_q, pos_d;
  logic [3:0]  flags_q, flags_d;
  logic        rej_q, rej_d;

  logic        res_valid_q, res_valid_d;
  logic [63:0] res_chunk_q, res_chunk_d;
  logic [3:0]  res_nbytes_q, res_nbytes_d;
  logic        res_status_q, res_status_d;
  logic        res_last_q, res_last_d;

  logic          acc;
  logic [15:0]   pos_adv;
  logic [55:0]   win_base, win_new;
  logic [3:0]    flags_new;
  logic          rej_new;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          store_ready;
  logic [16:0]   size17, off17, end17, rem17;
  logic [7:0]    rd_n;
  logic          file_ok;
  rd_cmd_t       rd_cmd;
  rd_res_t       rd_res;
  logic          rd_busy;

  assign busy_o      = !store_ready || rd_busy;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    acc      = start_i && !busy_o;
    pos_adv  = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
    win_base = (pos_q == 16'd0) ? 56'd0 : win_q;
    win_new  = {win_base[47:0], data_byte_i};
    flags_new = (pos_q == 16'd0) ? 4'd0 : flags_q;
    if (pos_q >= 16'd6 && (pos_q - 16'd6) < Span && win_new == AppId) begin
      flags_new[0] = 1'b1;
    end
    if (pos_q >= 16'd1 && (pos_q - 16'd1) < Span) begin
      if (win_new[15:0] == cap_id_q) begin
        flags_new[1] = 1'b1;
      end
      if (win_new[15:0] == data_id_q) begin
        flags_new[2] = 1'b1;
      end
    end
    if (pos_q >= 16'd5 && (pos_q - 16'd5) < Span && win_new[47:0] == SelPattern) begin
      flags_new[3] = 1'b1;
    end

    off17   = {1'b0, file_offset_i};
    end17   = off17 + 17'(byte_length_i);
    rej_new = (pos_q == 16'd0) ? (file_q != FileData || end17 > FileEnd) : rej_q;
    mem_we    = acc && func_i == FuncUpdate && !rej_new && pos_q < {8'd0, byte_length_i};
    mem_waddr = AW'(file_offset_i + pos_q);

    file_ok = (file_q == FileCc) || (file_q == FileData);
    size17  = (file_q == FileCc) ? 17'(CcBytes) : FileEnd;
    rem17   = size17 - off17;
    if (off17 >= size17) begin
      rd_n = 8'd0;
    end else if (end17 > size17) begin
      rd_n = rem17[7:0];
    end else begin
      rd_n = byte_length_i;
    end

    cap_id_d  = cap_id_q;
    data_id_d = data_id_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegCapId:  cap_id_d  = cfg_data_i;
        RegDataId: data_id_d = cfg_data_i;
        default: ;
      endcase
    end

    phase_d = phase_q;
    file_d  = file_q;
    win_d   = win_q;
    pos_d   = pos_q;
    flags_d = flags_q;
    rej_d   = rej_q;

    rd_cmd        = '0;
    rd_cmd.off    = file_offset_i;
    rd_cmd.n      = rd_n;
    rd_cmd.cap    = (file_q == FileCc);

    res_valid_d  = rd_res.valid;
    res_chunk_d  = rd_res.chunk;
    res_nbytes_d = rd_res.nbytes;
    res_status_d = 1'b0;
    res_last_d   = rd_res.last;

    if (acc) begin
      unique case (func_i)
        FuncSelect: begin
          win_d   = win_new;
          flags_d = flags_new;
          pos_d   = pos_adv;
          if (data_last_i) begin
            pos_d        = 16'd0;
            res_valid_d  = 1'b1;
            res_chunk_d  = 64'd0;
            res_nbytes_d = 4'd0;
            res_last_d   = 1'b1;
            if (flags_new[0]) begin
              phase_d = PhaseApp;
            end else if (phase_q != PhaseIdle && flags_new[1]) begin
              phase_d = PhaseCc;
              file_d  = FileCc;
            end else if (phase_q != PhaseIdle && (flags_new[2] || flags_new[3])) begin
              phase_d = PhaseData;
              file_d  = FileData;
            end else begin
              phase_d      = PhaseIdle;
              res_status_d = 1'b1;
            end
          end
        end
        FuncRead: begin
          pos_d = 16'd0;
          if (file_ok && rd_n != 8'd0) begin
            rd_cmd.launch = 1'b1;
          end else begin
            res_valid_d  = 1'b1;
            res_chunk_d  = 64'd0;
            res_nbytes_d = 4'd0;
            res_status_d = !file_ok;
            res_last_d   = 1'b1;
          end
        end
        FuncUpdate: begin
          rej_d = rej_new;
          pos_d = pos_adv;
          if (data_last_i) begin
            pos_d        = 16'd0;
            res_valid_d  = 1'b1;
            res_chunk_d  = 64'd0;
            res_nbytes_d = 4'd0;
            res_status_d = rej_new;
            res_last_d   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_id_q    <= CapIdReset;
      data_id_q   <= DataIdReset;
      phase_q     <= PhaseIdle;
      file_q      <= FileNone;
      win_q       <= '0;
      pos_q       <= '0;
      flags_q     <= '0;
      rej_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      cap_id_q    <= cap_id_d;
      data_id_q   <= data_id_d;
      phase_q     <= phase_d;
      file_q      <= file_d;
      win_q       <= win_d;
      pos_q       <= pos_d;
      flags_q     <= flags_d;
      rej_q       <= rej_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_chunk_q  <= res_chunk_d;
    res_nbytes_q <= res_nbytes_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  assign result_valid_o = res_valid_q;
  assign read_chunk_o   = res_chunk_q;
  assign chunk_bytes_o  = res_nbytes_q;
  assign status_o       = res_status_q;
  assign result_last_o  = res_last_q;

  tfe_store #(
    .DATA_FILE_BYTES(DATA_FILE_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(data_byte_i),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata),
    .ready_o(store_ready)
  );

  tfe_reader #(
    .DATA_FILE_BYTES(DATA_FILE_BYTES)
  ) u_reader (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (rd_cmd),
    .data_file_id_i(data_id_q),
    .re_o          (mem_re),
    .raddr_o       (mem_raddr),
    .rdata_i       (mem_rdata),
    .res_o         (rd_res),
    .busy_o        (rd_busy)
  );

endmodule

// ===== rtl/tfe_checker.sv =====
module tfe_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic [1:0]                  func_i,
  input logic                        data_last_i,
  input logic                        result_valid_o,
  input logic [3:0]                  chunk_bytes_o,
  input logic                        status_o,
  input logic                        result_last_o
);
  import tfe_pkg::*;

  a_chunk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> chunk_bytes_o <= 4'd8)
    else $error("chunk byte count out of range");

  a_inner_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_last_o |-> chunk_bytes_o == 4'd8 && !status_o)
    else $error("a result that is not last must carry a full chunk and ok status");

  a_mid_stream_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !data_last_i && (func_i == FuncSelect || func_i == FuncUpdate)
    |=> !result_valid_o)
    else $error("a data item that is not last produced a result");

  a_read_responds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && func_i == FuncRead |=> busy_o || result_valid_o)
    else $error("a read transaction neither started nor answered");

endmodule

bind type4_tag_file_engine tfe_checker u_tfe_checker (.*);
